// ===== rtl/cbm_pkg.sv =====
// Shared types, codes and constants of the cartridge bank mapper.
package cbm_pkg;

  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ROM_ADDR_W = 22;
  localparam int unsigned BANK_W     = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned SIZE_W     = 2;

  localparam int unsigned RAM_DEPTH_DEFAULT = 8192;

  typedef enum logic [1:0] {
    KIND_ROM   = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_t;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CART_TYPE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAM_SIZE  = 1'd1;

  localparam logic [BYTE_W-1:0] CART_MBC1       = 8'h02;
  localparam logic [BYTE_W-1:0] CART_MBC1_RAM   = 8'h03;
  localparam logic [BYTE_W-1:0] OPEN_BUS        = 8'hFF;
  localparam logic [3:0]        RAM_ENABLE_KEY  = 4'hA;
  localparam logic [BANK_W-1:0] BANK_RESET      = 8'h01;

  localparam logic [SIZE_W-1:0] SIZE_NONE = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_2K   = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_8K   = 2'd2;
  localparam logic [SIZE_W-1:0] SIZE_32K  = 2'd3;

  localparam logic [ADDR_W-1:0] MASK_2K  = 16'h07FF;
  localparam logic [ADDR_W-1:0] MASK_8K  = 16'h1FFF;
  localparam logic [ADDR_W-1:0] MASK_32K = 16'h7FFF;

  // Address regions by the top three address bits (8 KiB each).
  localparam logic [2:0] RGN_RAM_EN  = 3'd0;
  localparam logic [2:0] RGN_BANK    = 3'd1;
  localparam logic [2:0] RGN_MODE    = 3'd3;
  localparam logic [2:0] RGN_EXT_RAM = 3'd5;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] value;
  } req_t;

  typedef struct packed {
    kind_t                 kind;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic [BYTE_W-1:0]     read_data;
    logic                  use_ram;
  } res_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] offset;
    logic [BYTE_W-1:0] wdata;
  } ram_req_t;

endpackage

// ===== rtl/cbm_if.sv =====
// Valid/ready channel interfaces for bus requests and mapper results.
interface cbm_req_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [cbm_pkg::ADDR_W-1:0]  address;
  logic [cbm_pkg::BYTE_W-1:0]  value;

  modport source (output valid, func, address, value, input ready);
  modport sink   (input valid, func, address, value, output ready);
endinterface

interface cbm_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      kind;
  logic [cbm_pkg::ROM_ADDR_W-1:0]  rom_address;
  logic [cbm_pkg::BYTE_W-1:0]      read_data;

  modport source (output valid, kind, rom_address, read_data, input ready);
  modport sink   (input valid, kind, rom_address, read_data, output ready);
endinterface

// ===== rtl/cartridge_bank_mapper_core.sv =====
// Top level of the cartridge bank mapper: request register, decode, RAM and result register.
//
//   Channel  Dir  Fields                          Handshake
//   req      in   func, address, value            req.valid / req.ready
//   rsp      out  kind, rom_address, read_data    rsp.valid / rsp.ready
//   cfg      in   cfg_index, cfg_data             cfg_we, no back-pressure
//
// One request is accepted per cycle unless a stalled result or the RAM clear holds it off; it
// passes the request register, then the result register. After reset the RAM is cleared one
// entry a cycle over all RAM_DEPTH entries, with req.ready low. A stalled result holds the
// result and request registers; the RAM read is issued only when a request moves into the result register.
module cartridge_bank_mapper_core #(
  parameter int unsigned RAM_DEPTH = cbm_pkg::RAM_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbm_pkg::CFG_DATA_W-1:0] cfg_data,
  cbm_req_if.sink                        req,
  cbm_rsp_if.source                      rsp
);

  localparam int unsigned AW = $clog2(RAM_DEPTH);

  logic              clearing;
  logic [AW-1:0]     clr_addr;

  logic              req_valid;
  cbm_pkg::req_t     req_reg;
  logic              fire;

  logic              rsp_valid;
  cbm_pkg::res_t     rsp_reg;

  cbm_pkg::res_t     res;
  cbm_pkg::ram_req_t ram;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [cbm_pkg::BYTE_W-1:0] mem_wdata;
  logic [cbm_pkg::BYTE_W-1:0] mem_rdata;

  assign fire      = req_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !clearing && (!req_valid || fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(RAM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req.ready) begin
      req_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      req_reg.func    <= req.func;
      req_reg.address <= req.address;
      req_reg.value   <= req.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!rsp_valid || rsp.ready) begin
      rsp_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_reg <= res;
    end
  end

  cbm_decode #(
    .RAM_DEPTH (RAM_DEPTH)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .req       (req_reg),
    .res       (res),
    .ram       (ram)
  );

  assign mem_we    = clearing || ram.we;
  assign mem_waddr = clearing ? clr_addr : ram.offset[AW-1:0];
  assign mem_wdata = clearing ? '0 : ram.wdata;

  cbm_ram #(
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (ram.re),
    .raddr (ram.offset[AW-1:0]),
    .rdata (mem_rdata)
  );

  assign rsp.valid       = rsp_valid;
  assign rsp.kind        = rsp_reg.kind;
  assign rsp.rom_address = rsp_reg.rom_address;
  assign rsp.read_data   = rsp_reg.use_ram ? mem_rdata : rsp_reg.read_data;

`ifndef SYNTHESIS
  a_reset_starts_clear: assert property (@(posedge clk) rst |=> clearing)
    else $error("RAM clear did not start after reset.");

  a_no_request_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req.ready)
    else $error("Request taken while the RAM is being cleared.");

  a_ram_only_for_data: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_reg.use_ram) |-> (rsp_reg.kind == cbm_pkg::KIND_DATA))
    else $error("RAM data selected for a result that is not a data byte.");

  a_result_follows_request: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp_valid)
    else $error("Request left the request register without producing a result.");
`endif

endmodule

// ===== rtl/cbm_ram.sv =====
// Single-port-write, single-port-read cartridge RAM with registered read data.
module cbm_ram #(
  parameter int unsigned DEPTH = cbm_pkg::RAM_DEPTH_DEFAULT,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [cbm_pkg::BYTE_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [cbm_pkg::BYTE_W-1:0] rdata
);

  logic [cbm_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/cbm_decode.sv =====
// Mapper registers and the decode of one bus request into a result and a RAM access.
module cbm_decode #(
  parameter int unsigned RAM_DEPTH = cbm_pkg::RAM_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           fire,
  input  cbm_pkg::req_t                  req,
  output cbm_pkg::res_t                  res,
  output cbm_pkg::ram_req_t              ram
);

  localparam logic [cbm_pkg::ADDR_W-1:0] CAP_MASK = cbm_pkg::ADDR_W'(RAM_DEPTH - 1);

  logic [cbm_pkg::BYTE_W-1:0] cart_type;
  logic [cbm_pkg::SIZE_W-1:0] size_code;
  logic                       ram_enabled;
  logic                       ram_enabled_next;
  logic                       bank_mode;
  logic                       bank_mode_next;
  logic [cbm_pkg::BANK_W-1:0] bank_num;
  logic [cbm_pkg::BANK_W-1:0] bank_num_next;

  logic                       is_mbc1;
  logic [cbm_pkg::ADDR_W-1:0] size_mask;
  logic                       ram_ok;
  logic [2:0]                 region;

  always_ff @(posedge clk) begin
    if (rst) begin
      cart_type <= '0;
      size_code <= cbm_pkg::SIZE_NONE;
    end else if (cfg_we) begin
      case (cfg_index)
        cbm_pkg::REG_CART_TYPE: cart_type <= cfg_data;
        cbm_pkg::REG_RAM_SIZE:  size_code <= cfg_data[cbm_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enabled <= 1'b0;
      bank_mode   <= 1'b0;
      bank_num    <= cbm_pkg::BANK_RESET;
    end else if (fire) begin
      ram_enabled <= ram_enabled_next;
      bank_mode   <= bank_mode_next;
      bank_num    <= bank_num_next;
    end
  end

  assign is_mbc1 = (cart_type == cbm_pkg::CART_MBC1) || (cart_type == cbm_pkg::CART_MBC1_RAM);
  assign region  = req.address[cbm_pkg::ADDR_W-1 -: 3];

  // The RAM sizes are powers of two, so wrapping is a mask capped at the memory depth.
  always_comb begin
    case (size_code)
      cbm_pkg::SIZE_2K:  size_mask = cbm_pkg::MASK_2K & CAP_MASK;
      cbm_pkg::SIZE_8K:  size_mask = cbm_pkg::MASK_8K & CAP_MASK;
      cbm_pkg::SIZE_32K: size_mask = cbm_pkg::MASK_32K & CAP_MASK;
      default:           size_mask = '0;
    endcase
  end

  assign ram_ok = ram_enabled && (size_code != cbm_pkg::SIZE_NONE);

  always_comb begin
    ram_enabled_next = ram_enabled;
    bank_mode_next   = bank_mode;
    bank_num_next    = bank_num;
    res.kind         = cbm_pkg::KIND_DATA;
    res.rom_address  = '0;
    res.read_data    = '0;
    res.use_ram      = 1'b0;
    ram.we           = 1'b0;
    ram.re           = 1'b0;
    ram.offset       = {3'b000, req.address[12:0]} & size_mask;
    ram.wdata        = req.value;

    if (req.func == cbm_pkg::FUNC_WRITE) begin
      res.kind = cbm_pkg::KIND_WRITE;
      if (is_mbc1) begin
        case (region)
          cbm_pkg::RGN_RAM_EN: ram_enabled_next = (req.value[3:0] == cbm_pkg::RAM_ENABLE_KEY);
          cbm_pkg::RGN_BANK:   bank_num_next = (req.value == '0) ? cbm_pkg::BANK_RESET
                                                                 : req.value;
          cbm_pkg::RGN_MODE:   bank_mode_next = req.value[0];
          cbm_pkg::RGN_EXT_RAM: ram.we = fire && ram_ok;
          default: ;
        endcase
      end
    end else if (!is_mbc1 || !req.address[15]) begin
      res.kind = cbm_pkg::KIND_ROM;
      if (is_mbc1 && req.address[14]) begin
        res.rom_address = {bank_num, req.address[13:0]};
      end else begin
        res.rom_address = cbm_pkg::ROM_ADDR_W'(req.address);
      end
    end else if (region == cbm_pkg::RGN_EXT_RAM && ram_ok) begin
      res.use_ram = 1'b1;
      ram.re      = fire;
    end else begin
      res.read_data = cbm_pkg::OPEN_BUS;
    end
  end

endmodule

// ===== tb/sv/cbm_access_checker.sv =====
// Checker that predicts the mapper result of every accepted request and compares it.
module cbm_access_checker
  import cbm_pkg::*;
#(
  parameter int unsigned RAM_DEPTH = RAM_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  req_valid,
  input  logic                  req_ready,
  input  logic                  req_func,
  input  logic [ADDR_W-1:0]     req_address,
  input  logic [BYTE_W-1:0]     req_value,
  input  logic                  rsp_valid,
  input  logic                  rsp_ready,
  input  logic [1:0]            rsp_kind,
  input  logic [ROM_ADDR_W-1:0] rsp_rom_address,
  input  logic [BYTE_W-1:0]     rsp_read_data,
  output int                    errors,
  output int                    outstanding,
  output int                    checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_t                 kind;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic [BYTE_W-1:0]     read_data;
  } access_result_t;

  access_result_t    pending_results[$];
  logic [BYTE_W-1:0] cart_type;
  logic [SIZE_W-1:0] size_code;
  logic              ram_on;
  logic              bank_mode_q;
  logic [BANK_W-1:0] bank;
  logic [BYTE_W-1:0] ram_img [RAM_DEPTH];
  int                err_cnt = 0;
  int                check_cnt = 0;

  initial begin
    errors = 0;
    outstanding = 0;
    checked = 0;
  end

  function automatic access_result_t map_access(logic func, logic [ADDR_W-1:0] addr,
                                                logic [BYTE_W-1:0] val);
    access_result_t res;
    int unsigned    span;
    logic           mbc;
    res = '{kind: KIND_DATA, rom_address: '0, read_data: '0};
    case (size_code)
      SIZE_2K:  span = 'h800;
      SIZE_8K:  span = 'h2000;
      SIZE_32K: span = 'h8000;
      default:  span = 0;
    endcase
    if (span > RAM_DEPTH) span = RAM_DEPTH;
    mbc = (cart_type == CART_MBC1) || (cart_type == CART_MBC1_RAM);
    if (func == FUNC_WRITE) begin
      res.kind = KIND_WRITE;
      if (mbc) begin
        case (addr[15:13])
          RGN_RAM_EN:  ram_on = (val[3:0] == RAM_ENABLE_KEY);
          RGN_BANK:    bank = (val == '0) ? BANK_RESET : val;
          RGN_MODE:    bank_mode_q = val[0];
          RGN_EXT_RAM: if (ram_on && span != 0) ram_img[addr[12:0] % span] = val;
          default: ;
        endcase
      end
    end else if (!mbc || addr[15:14] == 2'b00) begin
      res.kind = KIND_ROM;
      res.rom_address = ROM_ADDR_W'(addr);
    end else if (!addr[15]) begin
      res.kind = KIND_ROM;
      res.rom_address = ROM_ADDR_W'(bank) * ROM_ADDR_W'('h4000)
                      + ROM_ADDR_W'(addr - 16'h4000);
    end else if (addr[15:13] == RGN_EXT_RAM && ram_on && span != 0) begin
      res.read_data = ram_img[addr[12:0] % span];
    end else begin
      res.read_data = OPEN_BUS;
    end
    return res;
  endfunction

  function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    access_result_t want;
    if (rst) begin
      cart_type = '0;
      size_code = SIZE_NONE;
      ram_on = 1'b0;
      bank_mode_q = 1'b0;
      bank = BANK_RESET;
      for (int i = 0; i < RAM_DEPTH; i++) ram_img[i] = '0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_CART_TYPE) cart_type = cfg_data;
        else if (cfg_index == REG_RAM_SIZE) size_code = cfg_data[SIZE_W-1:0];
      end
      if (rsp_valid && rsp_ready) begin
        if (pending_results.size() == 0) begin
          err_cnt++;
          $display("%0t: result with no request outstanding, expected none, actual %0h/%0h/%0h",
                   $time, rsp_kind, rsp_rom_address, rsp_read_data);
        end else begin
          want = pending_results.pop_front();
          compare_field("kind", want.kind, rsp_kind);
          compare_field("rom_address", want.rom_address, rsp_rom_address);
          compare_field("read_data", want.read_data, rsp_read_data);
          check_cnt++;
        end
      end
      if (req_valid && req_ready)
        pending_results.push_back(map_access(req_func, req_address, req_value));
    end
    errors <= err_cnt;
    checked <= check_cnt;
    outstanding <= pending_results.size();
  end

endmodule

// ===== tb/sv/tb_cartridge_bank_mapper_core.sv =====
// Testbench top: drives bus requests and register settings into the mapper and gives the verdict.
module tb_cartridge_bank_mapper_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cbm_pkg::*;

  localparam int LONG_HOLD        = 300;
  localparam int WATCHDOG_LIMIT   = 20000;
  localparam int SETTLE           = 4;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int PHASES           = 6;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cbm_req_if req_ch ();
  cbm_rsp_if rsp_ch ();

  int  errors;
  int  outstanding;
  int  checked;
  int  sent = 0;
  int  settings_used = 0;
  int  idle_pct = 20;
  int  quiet_cycles = 0;
  bit  hold_rsp = 1'b0;

  logic [BYTE_W-1:0] phase_cart [PHASES] = '{CART_MBC1, CART_MBC1_RAM, 8'hFF, CART_MBC1,
                                              8'h00, CART_MBC1_RAM};
  logic [SIZE_W-1:0] phase_size [PHASES] = '{SIZE_2K, SIZE_32K, SIZE_32K, SIZE_NONE,
                                              SIZE_8K, SIZE_8K};
  int                phase_idle [PHASES] = '{20, 30, 10, 25, 15, 0};

  cartridge_bank_mapper_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  cbm_access_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .req_valid       (req_ch.valid),
    .req_ready       (req_ch.ready),
    .req_func        (req_ch.func),
    .req_address     (req_ch.address),
    .req_value       (req_ch.value),
    .rsp_valid       (rsp_ch.valid),
    .rsp_ready       (rsp_ch.ready),
    .rsp_kind        (rsp_ch.kind),
    .rsp_rom_address (rsp_ch.rom_address),
    .rsp_read_data   (rsp_ch.read_data),
    .errors          (errors),
    .outstanding     (outstanding),
    .checked         (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic issue_access(logic func, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] val);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.func    <= func;
    req_ch.address <= addr;
    req_ch.value   <= val;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sent++;
  endtask

  task automatic random_access();
    int                pick;
    logic              func;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] val;
    pick = $urandom_range(0, 99);
    func = FUNC_WRITE;
    val  = 8'($urandom);
    if (pick < 12) begin
      addr = 16'($urandom_range(0, 'h1FFF));
      if ($urandom_range(0, 3) != 0) val[3:0] = RAM_ENABLE_KEY;
    end else if (pick < 20) begin
      addr = 16'($urandom_range('h2000, 'h3FFF));
      if ($urandom_range(0, 7) == 0) val = '0;
    end else if (pick < 24) begin
      addr = 16'($urandom_range('h6000, 'h7FFF));
    end else if (pick < 72) begin
      // Half of the RAM traffic hits a few offsets and their aliases so reads find data.
      if ($urandom_range(0, 1) != 0)
        addr = 16'($urandom_range('hA000, 'hBFFF));
      else
        addr = 16'hA000 + 16'($urandom_range(0, 15)) + 16'($urandom_range(0, 3) * 'h800);
      if (pick >= 48) func = FUNC_READ;
    end else if (pick < 84) begin
      func = FUNC_READ;
      addr = 16'($urandom_range(0, 'h7FFF));
    end else begin
      func = 1'($urandom);
      addr = 16'($urandom);
    end
    issue_access(func, addr, val);
  endtask

  task automatic apply_settings(logic [BYTE_W-1:0] cart, logic [SIZE_W-1:0] size);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CART_TYPE;
    cfg_data  <= cart;
    @(posedge clk);
    cfg_index <= REG_RAM_SIZE;
    cfg_data  <= CFG_DATA_W'(size);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_rsp = 1'b0;
        rsp_ch.ready <= 1'b1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 3) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_CART_TYPE;
    cfg_data       <= '0;
    req_ch.valid   <= 1'b0;
    req_ch.func    <= FUNC_READ;
    req_ch.address <= '0;
    req_ch.value   <= '0;
    phase_cart[4] = 8'($urandom_range(4, 254));
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Flat map: reads go straight to ROM and writes change nothing.
    apply_settings(8'h00, SIZE_NONE);
    issue_access(FUNC_READ, 16'h0000, 8'h00);
    issue_access(FUNC_READ, 16'hFFFF, 8'hFF);
    issue_access(FUNC_WRITE, 16'h0000, 8'h0A);
    issue_access(FUNC_READ, 16'hA000, 8'h00);
    drain();

    apply_settings(CART_MBC1_RAM, SIZE_8K);
    issue_access(FUNC_READ, 16'h4000, 8'h00);
    issue_access(FUNC_READ, 16'hA000, 8'h00);
    issue_access(FUNC_WRITE, 16'h0000, 8'h0A);
    issue_access(FUNC_WRITE, 16'hA000, 8'h55);
    issue_access(FUNC_WRITE, 16'hBFFF, 8'hAA);
    issue_access(FUNC_READ, 16'hA000, 8'h00);
    issue_access(FUNC_READ, 16'hBFFF, 8'h00);
    issue_access(FUNC_WRITE, 16'h2000, 8'h00);
    issue_access(FUNC_READ, 16'h7FFF, 8'h00);
    issue_access(FUNC_WRITE, 16'h3FFF, 8'hFF);
    issue_access(FUNC_READ, 16'h7FFF, 8'h00);
    issue_access(FUNC_WRITE, 16'h6000, 8'h01);
    issue_access(FUNC_WRITE, 16'h7FFF, 8'h00);
    issue_access(FUNC_WRITE, 16'h4000, 8'h12);
    issue_access(FUNC_READ, 16'h8000, 8'h00);
    issue_access(FUNC_READ, 16'hFFFF, 8'h00);
    issue_access(FUNC_WRITE, 16'hC000, 8'h34);
    issue_access(FUNC_WRITE, 16'h1FFF, 8'hFA);
    issue_access(FUNC_WRITE, 16'h0000, 8'h00);
    issue_access(FUNC_READ, 16'hBFFF, 8'h00);
    issue_access(FUNC_WRITE, 16'h1000, 8'h5A);
    issue_access(FUNC_READ, 16'h3FFF, 8'h00);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      apply_settings(phase_cart[p], phase_size[p]);
      idle_pct = phase_idle[p];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // Hold results back long enough that the mapper fills and stalls new requests.
        if (p == 1 && n == 40) hold_rsp = 1'b1;
        random_access();
      end
    end
    drain();

    $display("Summary: %0d requests under %0d register settings, %0d results checked.",
             sent, settings_used, checked);
    $display("The run covered flat and MBC1 maps, RAM from none to 32 KiB, and a long stall.");
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
